### rtl/pde_pkg.sv
package pde_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int IDX_OUT_W = 6;
  localparam int DIST_W    = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_FULL
  } state_t;

  // controller -> datapath command for one cycle
  typedef struct packed {
    logic wr;     // store the arriving point
    logic issue;  // launch one request down the distance pipeline
    logic zero;   // force distance to zero (diagonal or dropped point)
    logic last;
    logic full;
  } cmd_t;

  // sideband that travels with each request through the pipeline
  typedef struct packed {
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 zero;
    logic                 last;
    logic                 full;
  } tag_t;

endpackage

### rtl/pde_ctrl.sv
module pde_ctrl #(
  parameter int MAX_POINTS = pde_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_new_set,
  input  logic                          dp_adv,
  output pde_pkg::cmd_t                 cmd,
  output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0] row_addr
);
  import pde_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    in_stall  = 1'b1;
    wr_addr   = in_new_set ? '0 : count_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!in_new_set && count_r == CNT_W'(MAX_POINTS)) begin
            state_nxt = ST_FULL;
          end else begin
            cmd.wr    = 1'b1;
            row_nxt   = wr_addr;
            col_nxt   = '0;
            count_nxt = CNT_W'(wr_addr) + CNT_W'(1);
            state_nxt = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        if (dp_adv) begin
          cmd.issue = 1'b1;
          if (col_r == row_r) begin
            cmd.zero  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end
      end
      ST_FULL: begin
        if (dp_adv) begin
          cmd.issue = 1'b1;
          cmd.zero  = 1'b1;
          cmd.last  = 1'b1;
          cmd.full  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr  = col_r;
  assign row_addr = row_r;

endmodule

### rtl/pde_datapath.sv
module pde_datapath #(
  parameter int MAX_POINTS = pde_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pde_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pde_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pde_pkg::cmd_t                   cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]   row_addr,
  input  logic signed [COORD_BITS-1:0]    in_x_coord,
  input  logic signed [COORD_BITS-1:0]    in_y_coord,
  output logic                            dp_adv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pde_pkg::IDX_OUT_W-1:0]   out_row_index,
  output logic [pde_pkg::IDX_OUT_W-1:0]   out_col_index,
  output logic [pde_pkg::DIST_W-1:0]      out_distance,
  output logic                            out_last_of_row,
  output logic                            out_store_full
);
  import pde_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NSTG   = ROOT_W;
  localparam int EXT_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

  function automatic logic [IDX_OUT_W-1:0] idx_out(input logic [IDX_W-1:0] a);
    logic [IDX_W+IDX_OUT_W-1:0] t;
    t = (IDX_W + IDX_OUT_W)'(a);
    return t[IDX_OUT_W-1:0];
  endfunction

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                 input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // point store
  logic [2*COORD_BITS-1:0] store_mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] q_r;

  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic signed [COORD_BITS-1:0] px_a_r, py_a_r;
  logic                         va_r, vb_r, vc_r;
  tag_t                         tag_in, tag_a_r, tag_b_r, tag_c_r;
  logic [DIFF_W-1:0]            dx_r, dy_r;
  logic [SQ_W-1:0]              sqx_r, sqy_r;
  logic [SQ_W-1:0]              sq_sum;

  // square root stages, one result bit each
  logic [REM_W-1:0]  rem_r  [0:NSTG];
  logic [ROOT_W-1:0] root_r [0:NSTG];
  logic [RAD_W-1:0]  rad_r  [0:NSTG-1];
  logic              sv_r   [0:NSTG];
  tag_t              stag_r [0:NSTG];
  logic [REM_W-1:0]  rem_nxt  [1:NSTG];
  logic [ROOT_W-1:0] root_nxt [1:NSTG];

  logic [EXT_W-1:0]  root_ext;
  logic [DIST_W-1:0] dist_sat;

  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_row_r, out_col_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic                 out_last_r, out_full_r;

  assign dp_adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store_mem[wr_addr] <= {in_x_coord, in_y_coord};
    end
  end

  always_ff @(posedge clk) begin
    if (dp_adv) begin
      q_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      cur_x_r <= in_x_coord;
      cur_y_r <= in_y_coord;
    end
  end

  always_comb begin
    tag_in      = '0;
    tag_in.row  = cmd.full ? '0 : idx_out(row_addr);
    tag_in.col  = cmd.full ? '0 : idx_out(rd_addr);
    tag_in.zero = cmd.zero;
    tag_in.last = cmd.last;
    tag_in.full = cmd.full;
  end

  assign sq_sum = sqx_r + sqy_r;

  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    for (int i = 0; i < NSTG; i++) begin
      rem_sh = {rem_r[i][REM_W-3:0], rad_r[i][RAD_W-1 -: 2]};
      trial  = {root_r[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[i+1]  = rem_sh - trial;
        root_nxt[i+1] = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i+1]  = rem_sh;
        root_nxt[i+1] = {root_r[i][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      for (int i = 0; i <= NSTG; i++) begin
        sv_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (dp_adv) begin
      va_r    <= cmd.issue;
      vb_r    <= va_r;
      vc_r    <= vb_r;
      sv_r[0] <= vc_r;
      for (int i = 1; i <= NSTG; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
      out_valid_r <= sv_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_adv) begin
      px_a_r  <= cur_x_r;
      py_a_r  <= cur_y_r;
      tag_a_r <= tag_in;

      dx_r    <= abs_diff(px_a_r, q_r[2*COORD_BITS-1:COORD_BITS]);
      dy_r    <= abs_diff(py_a_r, q_r[COORD_BITS-1:0]);
      tag_b_r <= tag_a_r;

      sqx_r   <= dx_r * dx_r;
      sqy_r   <= dy_r * dy_r;
      tag_c_r <= tag_b_r;

      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= RAD_W'(sq_sum) << (2 * FRAC_BITS);
      stag_r[0] <= tag_c_r;
      for (int i = 1; i <= NSTG; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        stag_r[i] <= stag_r[i-1];
      end
      for (int i = 1; i < NSTG; i++) begin
        rad_r[i] <= rad_r[i-1] << 2;
      end
    end
  end

  always_comb begin
    root_ext = EXT_W'(root_r[NSTG]);
    if (root_ext > EXT_W'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = root_ext[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_adv) begin
      out_row_r  <= stag_r[NSTG].row;
      out_col_r  <= stag_r[NSTG].col;
      out_dist_r <= stag_r[NSTG].zero ? '0 : dist_sat;
      out_last_r <= stag_r[NSTG].last;
      out_full_r <= stag_r[NSTG].full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_distance    = out_dist_r;
  assign out_last_of_row = out_last_r;
  assign out_store_full  = out_full_r;

endmodule

### rtl/pairwise_euclidean_distance.sv
// Distance rows for a stream of 2-D points. Each accepted point k is stored
// and answered with k+1 results: the distances to stored points 0..k in
// order, the diagonal one zero and the last one flagged last_of_row. Distance
// is floor(sqrt(dx^2+dy^2) * 2^FRAC_BITS), saturated to 25 bits. new_set
// restarts the store at index zero; a point arriving on a full store is
// dropped and answered with one result with store_full and last_of_row set.
// Timing: point k holds the input while it is stored, then while the point
// store is read once per result; a dropped point holds it for its one result.
// Within a row, results leave at one per cycle when the output does not stall,
// passing the store read, difference, square, radicand, one stage per root bit
// and the output register; a stall on the output freezes the whole pipeline.
module pairwise_euclidean_distance #(
  parameter int MAX_POINTS = pde_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pde_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pde_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    in_x_coord,
  input  logic signed [COORD_BITS-1:0]    in_y_coord,
  input  logic                            in_new_set,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pde_pkg::IDX_OUT_W-1:0]   out_row_index,
  output logic [pde_pkg::IDX_OUT_W-1:0]   out_col_index,
  output logic [pde_pkg::DIST_W-1:0]      out_distance,
  output logic                            out_last_of_row,
  output logic                            out_store_full
);
  import pde_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  cmd_t             cmd;
  logic             dp_adv;
  logic [IDX_W-1:0] wr_addr, rd_addr, row_addr;

  pde_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_new_set (in_new_set),
    .dp_adv     (dp_adv),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .row_addr   (row_addr)
  );

  pde_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .wr_addr         (wr_addr),
    .rd_addr         (rd_addr),
    .row_addr        (row_addr),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .dp_adv          (dp_adv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_distance    (out_distance),
    .out_last_of_row (out_last_of_row),
    .out_store_full  (out_store_full)
  );

endmodule
